/* rtl/wgsp_pkg.sv */
// Shared types, constants and helper functions of the geometry string parser.
package wgsp_pkg;

  // Width at which parsed numbers and edge differences wrap.
  localparam int NUMBER_BITS = 32;
  localparam int OUT_BITS    = 32;
  localparam int SCREEN_BITS = 16;
  localparam int CFG_IDX_W   = 1;

  typedef logic [NUMBER_BITS-1:0] num_t;
  typedef logic [SCREEN_BITS-1:0] screen_t;
  typedef logic [7:0]             char_t;
  typedef logic [CFG_IDX_W-1:0]   cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_SCREEN_WIDTH  = 1'd0;
  localparam cfg_idx_t REG_SCREEN_HEIGHT = 1'd1;

  // Character codes.
  localparam char_t CH_NUL   = 8'h00;
  localparam char_t CH_EQ    = 8'h3D;
  localparam char_t CH_LX    = 8'h78;
  localparam char_t CH_UX    = 8'h58;
  localparam char_t CH_PLUS  = 8'h2B;
  localparam char_t CH_MINUS = 8'h2D;
  localparam char_t CH_ZERO  = 8'h30;
  localparam char_t CH_NINE  = 8'h39;

  typedef enum logic [10:0] {
    PH_START  = 11'b000_0000_0001,
    PH_FIRST  = 11'b000_0000_0010,
    PH_W_DIG  = 11'b000_0000_0100,
    PH_H_SIGN = 11'b000_0000_1000,
    PH_H_DIG  = 11'b000_0001_0000,
    PH_X_SIGN = 11'b000_0010_0000,
    PH_X_DIG  = 11'b000_0100_0000,
    PH_Y_SIGN = 11'b000_1000_0000,
    PH_Y_DIG  = 11'b001_0000_0000,
    PH_DONE   = 11'b010_0000_0000,
    PH_FAIL   = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic                       parse_ok;
    logic signed [OUT_BITS-1:0] pos_x;
    logic signed [OUT_BITS-1:0] pos_y;
    logic signed [OUT_BITS-1:0] size_w;
    logic signed [OUT_BITS-1:0] size_h;
  } result_t;

  function automatic logic is_digit(char_t c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Sign-extends (or truncates) a wrapped number into the result field width.
  function automatic logic signed [OUT_BITS-1:0] to_out(num_t v);
    logic signed [63:0] ext;
    ext = 64'(signed'(v));
    return ext[OUT_BITS-1:0];
  endfunction

endpackage

/* rtl/window_geometry_string_parser.sv */
// Top level of the window geometry string parser: input register, parser, result register.
//
// The block takes a geometry string such as "=640x480-10+20" one character per request
// on the in_ channel, terminated by a zero byte. Each terminator produces exactly one
// result request on the out_ channel: a success flag and the x, y, width and height
// values, with -1 for any value that was not given. Other characters produce nothing.
// Offsets written with a minus are counted from the right or bottom edge, using the
// screen_width (index 0) and screen_height (index 1) registers written through the
// cfg_ channel; a zero screen size leaves the offset as parsed. Write the registers
// only while no string is in flight. The cfg_ channel is always ready.
// A terminator waits in the input register until the result register has room, then
// its result is registered there. One character is taken per cycle while there is room,
// and each step of the parser state does a multiply-by-ten as two shifts and two adds.
// If the receiver stalls, the result waits in the output register; one more character
// is still taken into the input register, after which in_ready drops until the result
// leaves. Synchronous reset clears the parser to the start of a string, empties both
// registers and sets both screen sizes to zero.
module window_geometry_string_parser import wgsp_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  cfg_idx_t                   cfg_index,
  input  screen_t                    cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  char_t                      in_char_code,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_parse_ok,
  output logic signed [OUT_BITS-1:0] out_pos_x,
  output logic signed [OUT_BITS-1:0] out_pos_y,
  output logic signed [OUT_BITS-1:0] out_size_w,
  output logic signed [OUT_BITS-1:0] out_size_h
);

  screen_t screen_width_r;
  screen_t screen_height_r;
  logic    char_valid_r;
  char_t   char_r;
  logic    slot_free;
  logic    fire;
  logic    res_valid;
  result_t res_data;
  result_t out_data;

  // Configuration writes are registered and always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= '0;
      screen_height_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width_r  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held character is processed whenever the result register has room, so a
  // terminator never has to wait for a decision on whether it makes a result.
  assign fire     = char_valid_r && slot_free;
  assign in_ready = !char_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      char_valid_r <= 1'b1;
    end else if (fire) begin
      char_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r <= in_char_code;
    end
  end

  wgsp_parse u_parse (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (fire),
    .char_code     (char_r),
    .screen_width  (screen_width_r),
    .screen_height (screen_height_r),
    .res_valid     (res_valid),
    .res_data      (res_data)
  );

  wgsp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .load_data (res_data),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_parse_ok = out_data.parse_ok;
  assign out_pos_x    = out_data.pos_x;
  assign out_pos_y    = out_data.pos_y;
  assign out_size_w   = out_data.size_w;
  assign out_size_h   = out_data.size_h;

  // A result is only ever produced by a terminator character.
  a_result_on_nul: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> (char_r == CH_NUL))
    else $error("result produced by a non-terminator character");

  // A held character that was not processed must still be held next cycle.
  a_char_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (char_valid_r && !fire) |=> char_valid_r)
    else $error("held character lost before processing");

  // A new result appears only after a processed character.
  a_out_from_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(fire))
    else $error("result appeared without a processing step");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result register not empty after reset");

endmodule

/* rtl/wgsp_parse.sv */
// Parser state registers and the per-character next-state logic.
module wgsp_parse import wgsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  char_t   char_code,
  input  screen_t screen_width,
  input  screen_t screen_height,
  output logic    res_valid,
  output result_t res_data
);

  phase_t phase_r, phase_nxt;
  num_t   acc_r, acc_nxt;
  logic   neg_r, neg_nxt;
  logic   far_r, far_nxt;
  num_t   w_r, h_r, x_r, y_r;
  num_t   w_nxt, h_nxt, x_nxt, y_nxt;

  logic   dig, is_minus, is_pm;
  num_t   dig_val, acc_add, taken;
  num_t   x_base, y_base, x_edge0, y_edge0, x_edge, y_edge;
  logic   after_w, after_h, after_x, after_y;
  logic   emit, emit_ok;

  assign dig      = is_digit(char_code);
  assign is_minus = (char_code == CH_MINUS);
  assign is_pm    = (char_code == CH_PLUS) || is_minus;
  assign dig_val  = {{(NUMBER_BITS-4){1'b0}}, char_code[3:0]};
  assign acc_add  = (acc_r << 3) + (acc_r << 1) + dig_val;
  assign taken    = neg_r ? (num_t'(0) - acc_r) : acc_r;

  // Offsets after a minus count from the far edge when the screen size is known.
  assign x_base  = NUMBER_BITS'(screen_width);
  assign y_base  = NUMBER_BITS'(screen_height);
  assign x_edge  = (far_r && (screen_width  != '0)) ? (x_base - taken) : taken;
  assign y_edge  = (far_r && (screen_height != '0)) ? (y_base - taken) : taken;
  assign x_edge0 = (far_r && (screen_width  != '0)) ? x_base : '0;
  assign y_edge0 = (far_r && (screen_height != '0)) ? y_base : '0;

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    far_nxt   = far_r;
    w_nxt     = w_r;
    h_nxt     = h_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    after_w   = 1'b0;
    after_h   = 1'b0;
    after_x   = 1'b0;
    after_y   = 1'b0;
    emit      = 1'b0;
    emit_ok   = 1'b0;

    case (phase_r)
      PH_START, PH_FIRST: begin
        if ((phase_r == PH_START) && (char_code == CH_EQ)) begin
          phase_nxt = PH_FIRST;
        end else if (char_code == CH_NUL) begin
          emit = 1'b1;
        end else if (dig) begin
          acc_nxt   = dig_val;
          neg_nxt   = 1'b0;
          phase_nxt = PH_W_DIG;
        end else begin
          after_w = 1'b1;
        end
      end
      PH_W_DIG: begin
        if (dig) begin
          acc_nxt = acc_add;
        end else begin
          w_nxt   = taken;
          acc_nxt = '0;
          neg_nxt = 1'b0;
          after_w = 1'b1;
        end
      end
      PH_H_SIGN, PH_X_SIGN, PH_Y_SIGN: begin
        acc_nxt = '0;
        neg_nxt = 1'b0;
        if (is_minus) begin
          neg_nxt = 1'b1;
        end else if (dig) begin
          acc_nxt = dig_val;
        end
        if (is_minus || dig) begin
          case (phase_r)
            PH_H_SIGN: phase_nxt = PH_H_DIG;
            PH_X_SIGN: phase_nxt = PH_X_DIG;
            default:   phase_nxt = PH_Y_DIG;
          endcase
        end else begin
          // No digits: the number reads zero.
          case (phase_r)
            PH_H_SIGN: begin
              h_nxt   = '0;
              after_h = 1'b1;
            end
            PH_X_SIGN: begin
              x_nxt   = x_edge0;
              after_x = 1'b1;
            end
            default: begin
              y_nxt   = y_edge0;
              after_y = 1'b1;
            end
          endcase
        end
      end
      PH_H_DIG, PH_X_DIG, PH_Y_DIG: begin
        if (dig) begin
          acc_nxt = acc_add;
        end else begin
          acc_nxt = '0;
          neg_nxt = 1'b0;
          case (phase_r)
            PH_H_DIG: begin
              h_nxt   = taken;
              after_h = 1'b1;
            end
            PH_X_DIG: begin
              x_nxt   = x_edge;
              after_x = 1'b1;
            end
            default: begin
              y_nxt   = y_edge;
              after_y = 1'b1;
            end
          endcase
        end
      end
      PH_DONE: begin
        if (char_code == CH_NUL) begin
          emit    = 1'b1;
          emit_ok = 1'b1;
        end
      end
      default: begin
        if (char_code == CH_NUL) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_FAIL;
        end
      end
    endcase

    if (after_w) begin
      if ((char_code == CH_LX) || (char_code == CH_UX)) begin
        phase_nxt = PH_H_SIGN;
      end else begin
        after_h = 1'b1;
      end
    end
    if (after_h || after_x) begin
      if (char_code == CH_NUL) begin
        emit    = 1'b1;
        emit_ok = 1'b1;
      end else if (is_pm) begin
        far_nxt   = is_minus;
        phase_nxt = after_x ? PH_Y_SIGN : PH_X_SIGN;
      end else begin
        phase_nxt = PH_FAIL;
      end
    end
    if (after_y) begin
      if (char_code == CH_NUL) begin
        emit    = 1'b1;
        emit_ok = 1'b1;
      end else begin
        phase_nxt = PH_DONE;
      end
    end
  end

  assign res_valid         = step && emit;
  assign res_data.parse_ok = emit_ok;
  assign res_data.pos_x    = to_out(x_nxt);
  assign res_data.pos_y    = to_out(y_nxt);
  assign res_data.size_w   = to_out(w_nxt);
  assign res_data.size_h   = to_out(h_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n || (step && emit)) begin
      phase_r <= PH_START;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      far_r   <= 1'b0;
      w_r     <= '1;
      h_r     <= '1;
      x_r     <= '1;
      y_r     <= '1;
    end else if (step) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      far_r   <= far_nxt;
      w_r     <= w_nxt;
      h_r     <= h_nxt;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end
  end

endmodule

/* rtl/wgsp_out_reg.sv */
// Result register with valid and ready toward the receiver.
module wgsp_out_reg import wgsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t load_data,
  output logic    slot_free,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

endmodule

/* tb/sv/wgsp_tb_pkg.sv */
// Geometry string checker: mirrors the parser state and compares each result it emits.
package wgsp_tb_pkg;
  import wgsp_pkg::*;

  class geometry_checker;
    screen_t     screen_w;
    screen_t     screen_h;
    phase_t      ph;
    num_t        acc;
    bit          neg;
    bit          far_edge;
    num_t        w_val;
    num_t        h_val;
    num_t        x_val;
    num_t        y_val;
    result_t     expected_geometry[$];
    int unsigned failures;

    function new();
      screen_w = '0;
      screen_h = '0;
      failures = 0;
      restart();
    endfunction

    // Back to the start of a new string, nothing parsed yet.
    function void restart();
      ph       = PH_START;
      acc      = '0;
      neg      = 1'b0;
      far_edge = 1'b0;
      w_val    = '1;
      h_val    = '1;
      x_val    = '1;
      y_val    = '1;
    endfunction

    function void set_screen(cfg_idx_t idx, screen_t data);
      case (idx)
        REG_SCREEN_WIDTH:  screen_w = data;
        REG_SCREEN_HEIGHT: screen_h = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_geometry.size();
    endfunction

    function bit is_numeral(char_t c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function void push_digit(char_t c);
      acc = acc * num_t'(10) + num_t'(c - CH_ZERO);
    endfunction

    function num_t take_number();
      num_t v;
      v   = neg ? -acc : acc;
      acc = '0;
      neg = 1'b0;
      return v;
    endfunction

    function num_t from_edge(num_t v, screen_t s);
      if (far_edge && s != '0) return num_t'(s) - v;
      return v;
    endfunction

    function void emit(bit ok);
      result_t r;
      r.parse_ok = ok;
      r.pos_x    = x_val;
      r.pos_y    = y_val;
      r.size_w   = w_val;
      r.size_h   = h_val;
      expected_geometry.push_back(r);
      restart();
    endfunction

    // Returns 1 when the character belongs to the number being read.
    function bit number_char(char_t c, phase_t dig);
      if (ph == dig) begin
        if (is_numeral(c)) begin
          push_digit(c);
          return 1'b1;
        end
        return 1'b0;
      end
      acc = '0;
      neg = 1'b0;
      if (c == CH_MINUS) begin
        neg = 1'b1;
        ph  = dig;
        return 1'b1;
      end
      if (is_numeral(c)) begin
        push_digit(c);
        ph = dig;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void after_height(char_t c, phase_t next);
      if (c == CH_NUL) begin
        emit(1'b1);
      end else if (c == CH_PLUS || c == CH_MINUS) begin
        far_edge = (c == CH_MINUS);
        ph       = next;
      end else begin
        ph = PH_FAIL;
      end
    endfunction

    function void after_width(char_t c);
      if (c == CH_LX || c == CH_UX) ph = PH_H_SIGN;
      else after_height(c, PH_X_SIGN);
    endfunction

    function void take_char(char_t c);
      case (ph)
        PH_START, PH_FIRST: begin
          if (ph == PH_START && c == CH_EQ) begin
            ph = PH_FIRST;
          end else if (c == CH_NUL) begin
            emit(1'b0);
          end else if (is_numeral(c)) begin
            acc = '0;
            neg = 1'b0;
            push_digit(c);
            ph = PH_W_DIG;
          end else begin
            after_width(c);
          end
        end
        PH_W_DIG: begin
          if (!number_char(c, PH_W_DIG)) begin
            w_val = take_number();
            after_width(c);
          end
        end
        PH_H_SIGN, PH_H_DIG: begin
          if (!number_char(c, PH_H_DIG)) begin
            h_val = take_number();
            after_height(c, PH_X_SIGN);
          end
        end
        PH_X_SIGN, PH_X_DIG: begin
          if (!number_char(c, PH_X_DIG)) begin
            x_val = from_edge(take_number(), screen_w);
            after_height(c, PH_Y_SIGN);
          end
        end
        PH_Y_SIGN, PH_Y_DIG: begin
          if (!number_char(c, PH_Y_DIG)) begin
            y_val = from_edge(take_number(), screen_h);
            if (c == CH_NUL) emit(1'b1);
            else ph = PH_DONE;
          end
        end
        PH_DONE: begin
          if (c == CH_NUL) emit(1'b1);
        end
        default: begin
          if (c == CH_NUL) emit(1'b0);
          else ph = PH_FAIL;
        end
      endcase
    endfunction

    function void report(string field, logic signed [OUT_BITS-1:0] want,
                         logic signed [OUT_BITS-1:0] got);
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      failures++;
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_geometry.size() == 0) begin
        $display("%0t: result with none expected, actual ok=%0d x=%0d y=%0d w=%0d h=%0d",
                 $time, got.parse_ok, got.pos_x, got.pos_y, got.size_w, got.size_h);
        failures++;
        return;
      end
      want = expected_geometry.pop_front();
      if (got.parse_ok !== want.parse_ok) report("parse_ok", want.parse_ok, got.parse_ok);
      if (got.pos_x !== want.pos_x) report("pos_x", want.pos_x, got.pos_x);
      if (got.pos_y !== want.pos_y) report("pos_y", want.pos_y, got.pos_y);
      if (got.size_w !== want.size_w) report("size_w", want.size_w, got.size_w);
      if (got.size_h !== want.size_h) report("size_h", want.size_h, got.size_h);
    endfunction
  endclass

endpackage

/* tb/sv/window_geometry_string_parser_tb.sv */
// Testbench top for the window geometry string parser: directed and random strings.
module window_geometry_string_parser_tb;
  import wgsp_pkg::*;
  import wgsp_tb_pkg::*;

  // The watchdog limit is set well above the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // Characters to send in the random part.
  localparam int unsigned RANDOM_CHARS = 1100;
  // Characters between screen size changes.
  localparam int unsigned CFG_SPACING  = 180;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       cfg_valid;
  logic                       cfg_ready;
  cfg_idx_t                   cfg_index;
  screen_t                    cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  char_t                      in_char_code;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_parse_ok;
  logic signed [OUT_BITS-1:0] out_pos_x;
  logic signed [OUT_BITS-1:0] out_pos_y;
  logic signed [OUT_BITS-1:0] out_size_w;
  logic signed [OUT_BITS-1:0] out_size_h;

  geometry_checker sb;
  // When set, neither side idles; this gives stretches of full-rate traffic.
  bit              calm = 1'b0;
  int unsigned     cycles = 0;

  always #6 clk = ~clk;

  window_geometry_string_parser u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_parse_ok (out_parse_ok),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_size_w   (out_size_w),
    .out_size_h   (out_size_h)
  );

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // A character that is likely to matter to the parser: a digit, a separator, or any
  // nonzero byte including the high half of the code range.
  function automatic char_t random_glyph();
    case ($urandom_range(0, 3))
      0: return char_t'(CH_ZERO + $urandom_range(0, 9));
      1: begin
        case ($urandom_range(0, 4))
          0:       return CH_EQ;
          1:       return CH_LX;
          2:       return CH_UX;
          3:       return CH_PLUS;
          default: return CH_MINUS;
        endcase
      end
      default: return char_t'($urandom_range(1, 255));
    endcase
  endfunction

  // Appends a number with an optional leading minus. Most numbers are short; a few
  // are long enough to wrap the 32-bit accumulator, and some have no digits at all.
  function automatic void append_number(ref char_t s[$], input bit minus_ok);
    int unsigned r;
    int unsigned n;
    if (minus_ok && $urandom_range(0, 4) == 0) s.push_back(CH_MINUS);
    r = $urandom_range(0, 19);
    if (r == 0) n = 0;
    else if (r < 16) n = $urandom_range(1, 4);
    else if (r < 19) n = $urandom_range(5, 9);
    else n = $urandom_range(10, 14);
    repeat (n) s.push_back(char_t'(CH_ZERO + $urandom_range(0, 9)));
  endfunction

  // One character request. Valid stays high between back-to-back requests and is only
  // lowered when a gap is inserted in front of the next one.
  task automatic send_char(char_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (!in_ready);
    sb.take_char(c);
  endtask

  // Sends the text followed by the zero terminator.
  task automatic send_text(string t);
    for (int i = 0; i < t.len(); i++) send_char(char_t'(t[i]));
    send_char(CH_NUL);
  endtask

  // Waits until every expected result has arrived, then waits further so that both
  // pipeline registers are surely empty before registers change or the run ends.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Writes both screen sizes as two back-to-back register requests.
  task automatic write_screens(screen_t w, screen_t h);
    cfg_valid <= 1'b1;
    cfg_index <= REG_SCREEN_WIDTH;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    sb.set_screen(REG_SCREEN_WIDTH, w);
    cfg_index <= REG_SCREEN_HEIGHT;
    cfg_data  <= h;
    do @(posedge clk); while (!cfg_ready);
    sb.set_screen(REG_SCREEN_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Result side: every accepted result is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(result_t'({out_parse_ok, out_pos_x, out_pos_y,
                                 out_size_w, out_size_h}));
  end

  // Receiver: ready in bursts, with stalls of random length in between. A stall that
  // outlasts a result also backs up the input side once the input register is full.
  initial begin
    int unsigned hold;
    out_ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ready <= 1'b1;
        hold = $urandom_range(0, 6);
      end else begin
        out_ready <= 1'b0;
        hold = pick_gap();
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("window_geometry_string_parser test failed");
      $finish;
    end
  end

  initial begin
    char_t       line[$];
    int unsigned sent;
    int unsigned next_cfg;
    int unsigned round;
    sb = new();
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_SCREEN_WIDTH;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_char_code <= CH_NUL;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed strings, with both screen sizes still zero from reset, so a minus
    // offset keeps its parsed value.
    // The empty string, and the equals sign alone, both fail with every value -1.
    send_text("");
    send_text("=");
    // Height and x offset left without digits: a bare minus reads as zero, and the y
    // offset is not given. Uppercase X as the size separator.
    send_text("X-+-");
    // Width wraps at 32 bits, a second minus ends the height and opens the x offset,
    // and the characters after y (including byte 255) are ignored.
    send_text("9999999999x--5-7Z\377");
    // A byte of the high half fails the parse after the width was taken; the
    // following bytes are ignored up to the terminator.
    send_text("=1\200\377");
    drain();

    // Random strings. Most are well-formed geometry with random content; some get
    // one stray character, and the rest are noise. Screen sizes change between
    // groups of strings, each time with the block idle.
    sent     = 0;
    next_cfg = 0;
    round    = 0;
    while (sent < RANDOM_CHARS) begin
      if (sent >= next_cfg) begin
        drain();
        case (round % 6)
          0:       write_screens(16'hFFFF, 16'hFFFF);
          1:       write_screens(16'h0000, 16'hFFFF);
          2:       write_screens(screen_t'($urandom), 16'h0000);
          3:       write_screens(screen_t'($urandom), screen_t'($urandom));
          4:       write_screens(16'h0001, 16'h0001);
          default: write_screens(16'hFFFF, screen_t'($urandom));
        endcase
        round++;
        next_cfg += CFG_SPACING;
      end

      line.delete();
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 1) != 0) line.push_back(CH_EQ);
        if ($urandom_range(0, 3) != 0) append_number(line, 1'b0);
        if ($urandom_range(0, 2) != 0) begin
          line.push_back($urandom_range(0, 1) != 0 ? CH_LX : CH_UX);
          append_number(line, 1'b1);
        end
        if ($urandom_range(0, 2) != 0) begin
          line.push_back($urandom_range(0, 1) != 0 ? CH_PLUS : CH_MINUS);
          append_number(line, 1'b1);
          if ($urandom_range(0, 2) != 0) begin
            line.push_back($urandom_range(0, 1) != 0 ? CH_PLUS : CH_MINUS);
            append_number(line, 1'b1);
            // Trailing characters after y must be ignored, unless they continue its number.
            if ($urandom_range(0, 4) == 0)
              repeat ($urandom_range(1, 3)) line.push_back(random_glyph());
          end
        end
        // A few well-formed strings are broken by one stray character.
        if ($urandom_range(0, 7) == 0)
          line.insert($urandom_range(0, line.size()), random_glyph());
      end else begin
        repeat ($urandom_range(0, 8)) line.push_back(random_glyph());
      end
      line.push_back(CH_NUL);

      calm = ($urandom_range(0, 4) == 0);
      foreach (line[i]) send_char(line[i]);
      sent += line.size();
    end

    drain();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("window_geometry_string_parser test passed");
    end else begin
      $display("window_geometry_string_parser test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/wgsp_pkg.sv
rtl/wgsp_parse.sv
rtl/wgsp_out_reg.sv
rtl/window_geometry_string_parser.sv
tb/sv/wgsp_tb_pkg.sv
tb/sv/window_geometry_string_parser_tb.sv
